// ===== hw/rtl/gks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_pkg
// Shared sizes, register map, controller states and the command/status
// bundles between the controller and the datapath of the set-merge core.
// ----------------------------------------------------------------------------
package gks_pkg;

  localparam int MAX_SIDE = 64;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COUNT_W  = $clog2(CELLS + 1);
  localparam int SIDE_W   = 7;
  localparam int POS_W    = 6;
  localparam int PROD_W   = 2 * SIDE_W;
  localparam int MIN_SIDE = 2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_GRID_SIDE = 1'b0;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic DIR_RIGHT   = 1'b0;

  typedef enum logic [3:0] {
    ST_SIZE,
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_CHECK,
    ST_RSIZE,
    ST_RCLEAR,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic calc_a;
    logic calc_b;
    logic rd_a;
    logic rd_b;
    logic take_win;
    logic take_lose;
    logic merge;
    logic walk_start;
    logic scan;
    logic clear;
    logic size;
    logic load_count;
    logic load_res;
  } dp_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic bad;
    logic many_sets;
    logic differ;
    logic walk_end;
    logic clear_end;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hw/rtl/gks_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gks_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gks_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_ctrl
// Controller: sequences label sweeps, edge lookups, the merge scan and the
// hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
module gks_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  input  gks_pkg::dp_status_t st_i,
  output gks_pkg::dp_cmd_t    cmd_o
);

  gks_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gks_pkg::ST_SIZE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gks_pkg::ST_SIZE, gks_pkg::ST_RSIZE: begin
        cmd_o.size       = 1'b1;
        cmd_o.walk_start = 1'b1;
        state_d = (state_q == gks_pkg::ST_SIZE) ? gks_pkg::ST_CLEAR : gks_pkg::ST_RCLEAR;
      end
      gks_pkg::ST_CLEAR, gks_pkg::ST_RCLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_end) begin
          cmd_o.load_count = 1'b1;
          state_d = (state_q == gks_pkg::ST_CLEAR) ? gks_pkg::ST_IDLE : gks_pkg::ST_RESULT;
        end
      end
      gks_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = gks_pkg::ST_ADDR;
        end
      end
      gks_pkg::ST_ADDR: begin
        cmd_o.calc_a = 1'b1;
        state_d = gks_pkg::ST_CHECK;
      end
      gks_pkg::ST_CHECK: begin
        cmd_o.calc_b = 1'b1;
        if (st_i.is_restart) begin
          state_d = gks_pkg::ST_RSIZE;
        end else if (st_i.bad || !st_i.many_sets) begin
          state_d = gks_pkg::ST_RESULT;
        end else begin
          state_d = gks_pkg::ST_RD_A;
        end
      end
      gks_pkg::ST_RD_A: begin
        cmd_o.rd_a = 1'b1;
        state_d = gks_pkg::ST_RD_B;
      end
      gks_pkg::ST_RD_B: begin
        cmd_o.rd_b     = 1'b1;
        cmd_o.take_win = 1'b1;
        state_d = gks_pkg::ST_CMP;
      end
      gks_pkg::ST_CMP: begin
        cmd_o.take_lose = 1'b1;
        if (st_i.differ) begin
          cmd_o.merge      = 1'b1;
          cmd_o.walk_start = 1'b1;
          state_d = gks_pkg::ST_SCAN;
        end else begin
          state_d = gks_pkg::ST_RESULT;
        end
      end
      gks_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.walk_end) begin
          state_d = gks_pkg::ST_RESULT;
        end
      end
      gks_pkg::ST_RESULT: begin
        if (!st_i.out_full || out_ready_i) begin
          cmd_o.load_res = 1'b1;
          state_d = gks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gks_pkg::ST_SIZE;
      end
    endcase
    // a grid_side write always restarts the label store
    if (cfg_wr_i) begin
      state_d = gks_pkg::ST_SIZE;
    end
  end

endmodule

// ===== hw/rtl/gks_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_dp
// Datapath: input word registers, cell address math, label memory, merge
// scan pipeline, set counter and the output word register.
// ----------------------------------------------------------------------------
module gks_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gks_pkg::SIDE_W-1:0]  grid_side_i,
  input  logic                        cmd_i,
  input  logic [gks_pkg::POS_W-1:0]   row_i,
  input  logic [gks_pkg::POS_W-1:0]   col_i,
  input  logic                        dir_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        linked_o,
  output logic                        done_res_o,
  output logic                        bad_edge_o,
  output logic [gks_pkg::COUNT_W-1:0] sets_left_o,
  input  gks_pkg::dp_cmd_t            cmd_c_i,
  output gks_pkg::dp_status_t         st_o
);

  localparam int AW = gks_pkg::ADDR_W;
  localparam int CW = gks_pkg::COUNT_W;
  localparam int PW = gks_pkg::PROD_W;
  localparam int SW = gks_pkg::SIDE_W;

  logic [SW-1:0] side;
  logic          cmd_q, dir_q;
  logic [gks_pkg::POS_W-1:0] row_q, col_q;
  logic [AW-1:0] a_q, b_q, win_q, lose_q, pend_addr_q;
  logic          bad_q, linked_q, pend_q;
  logic [CW-1:0] n_q, idx_q, count_q;
  logic          out_valid_q, res_linked_q, res_bad_q;
  logic [CW-1:0] res_count_q;

  logic [PW-1:0] a_sum, b_sum, n_full;
  logic [SW-1:0] r2, c2;
  logic          idx_in;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  always_comb begin
    if (grid_side_i < SW'(gks_pkg::MIN_SIDE)) begin
      side = SW'(gks_pkg::MIN_SIDE);
    end else if (grid_side_i > SW'(gks_pkg::MAX_SIDE)) begin
      side = SW'(gks_pkg::MAX_SIDE);
    end else begin
      side = grid_side_i;
    end
  end

  assign a_sum  = PW'(row_q) * PW'(side) + PW'(col_q);
  assign b_sum  = PW'(a_q) + ((dir_q == gks_pkg::DIR_RIGHT) ? PW'(1) : PW'(side));
  assign n_full = PW'(side) * PW'(side);
  assign r2     = SW'(row_q) + SW'(dir_q);
  assign c2     = SW'(col_q) + SW'(dir_q == gks_pkg::DIR_RIGHT);
  assign idx_in = idx_q < n_q;

  // memory port steering
  always_comb begin
    ram_re    = cmd_c_i.rd_a | cmd_c_i.rd_b | (cmd_c_i.scan & idx_in);
    ram_raddr = cmd_c_i.rd_a ? a_q : (cmd_c_i.rd_b ? b_q : idx_q[AW-1:0]);
    if (cmd_c_i.clear) begin
      ram_we    = idx_in;
      ram_waddr = idx_q[AW-1:0];
      ram_wdata = idx_q[AW-1:0];
    end else begin
      ram_we    = cmd_c_i.scan & pend_q & (ram_rdata == lose_q);
      ram_waddr = pend_addr_q;
      ram_wdata = win_q;
    end
  end

  gks_ram #(
    .WIDTH (AW),
    .DEPTH (gks_pkg::CELLS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_c_i.capture) begin
      cmd_q <= cmd_i;
      row_q <= row_i;
      col_q <= col_i;
      dir_q <= dir_i;
    end
    if (cmd_c_i.calc_a) begin
      a_q   <= a_sum[AW-1:0];
      bad_q <= (r2 >= side) || (c2 >= side);
    end
    if (cmd_c_i.calc_b) begin
      b_q <= b_sum[AW-1:0];
    end
    if (cmd_c_i.take_win) begin
      win_q <= ram_rdata;
    end
    if (cmd_c_i.take_lose) begin
      lose_q <= ram_rdata;
    end
    if (cmd_c_i.size) begin
      n_q <= n_full[CW-1:0];
    end
    if (cmd_c_i.scan) begin
      pend_addr_q <= idx_q[AW-1:0];
    end
    if (cmd_c_i.load_res) begin
      res_linked_q <= linked_q;
      res_bad_q    <= bad_q & (cmd_q != gks_pkg::CMD_RESTART);
      res_count_q  <= count_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= 1'b0;
      linked_q    <= 1'b0;
      count_q     <= CW'(gks_pkg::CELLS);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_c_i.walk_start) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_c_i.scan || cmd_c_i.clear) begin
        if (idx_in) begin
          idx_q <= idx_q + CW'(1);
        end
        pend_q <= cmd_c_i.scan & idx_in;
      end
      if (cmd_c_i.capture) begin
        linked_q <= 1'b0;
      end else if (cmd_c_i.merge) begin
        linked_q <= 1'b1;
      end
      if (cmd_c_i.load_count) begin
        count_q <= n_q;
      end else if (cmd_c_i.merge) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_c_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.is_restart = (cmd_q == gks_pkg::CMD_RESTART);
  assign st_o.bad        = bad_q;
  assign st_o.many_sets  = count_q > CW'(1);
  assign st_o.differ     = ram_rdata != win_q;
  assign st_o.walk_end   = !idx_in && !pend_q;
  assign st_o.clear_end  = !idx_in;
  assign st_o.out_full   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign linked_o    = res_linked_q;
  assign done_res_o  = (res_count_q == CW'(1));
  assign bad_edge_o  = res_bad_q;
  assign sets_left_o = res_count_q;

endmodule

// ===== hw/rtl/grid_kruskal_set_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_kruskal_set_merge
// Set-label core for grid spanning-tree generation: restarts and edge merges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries one word: cmd, row, col, dir.
//   cmd = 0 relabels every cell in use with its own index; cmd = 1 offers
//   the edge from (row, col) to its right or lower neighbor.
//   Output channel (valid/ready) returns one word per input word: linked,
//   done_res, bad_edge, sets_left.
//   From input accept to output register: an off-grid edge or one set left
//   goes straight to the result; a same-set edge ends after its two label
//   reads; a merge scans the label memory one cell per cycle on its single
//   read port; a restart rewrites the labels, one label write per cycle.
//   One word is in flight at a time; in_ready_o is high only when idle, so a
//   new word can be taken in the cycle after the previous result is loaded.
//   Reset and every grid_side write start a label sweep over the side*side
//   cells in use (4096 after reset), during which no input word is taken.
//   A stalled output word holds in its register; the core may take and
//   work the next input word meanwhile and waits before overwriting it.
// ----------------------------------------------------------------------------
module grid_kruskal_set_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gks_pkg::PADDR_W-1:0]   paddr,
  input  logic [gks_pkg::PDATA_W-1:0]   pwdata,
  output logic [gks_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [gks_pkg::POS_W-1:0]     row_i,
  input  logic [gks_pkg::POS_W-1:0]     col_i,
  input  logic                          dir_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          linked_o,
  output logic                          done_res_o,
  output logic                          bad_edge_o,
  output logic [gks_pkg::COUNT_W-1:0]   sets_left_o
);

  logic [gks_pkg::SIDE_W-1:0] grid_side_q;
  logic                       reg_hit, cfg_wr;
  gks_pkg::dp_cmd_t           dp_cmd;
  gks_pkg::dp_status_t        dp_st;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[gks_pkg::PADDR_W-1:2] == gks_pkg::REG_GRID_SIDE);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? gks_pkg::PDATA_W'(grid_side_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= gks_pkg::SIDE_RESET;
    end else if (cfg_wr) begin
      grid_side_q <= pwdata[gks_pkg::SIDE_W-1:0];
    end
  end

  gks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .st_i        (dp_st),
    .cmd_o       (dp_cmd)
  );

  gks_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_side_i (grid_side_q),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .dir_i       (dir_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .linked_o    (linked_o),
    .done_res_o  (done_res_o),
    .bad_edge_o  (bad_edge_o),
    .sets_left_o (sets_left_o),
    .cmd_c_i     (dp_cmd),
    .st_o        (dp_st)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the grid set-merge core against its own label-memory predictor.
// Edge and restart words are driven in bursts with random gaps. Results are
// taken with random stalls and compared field by field. The grid side is
// changed over the APB port between phases, including the clamped extremes.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic CMD_EDGE = ~gks_pkg::CMD_RESTART;
  localparam logic DIR_DOWN = ~gks_pkg::DIR_RIGHT;
  localparam logic [gks_pkg::PADDR_W-1:0] SIDE_ADDR =
    gks_pkg::PADDR_W'(4 * gks_pkg::REG_GRID_SIDE);
  localparam logic [gks_pkg::PADDR_W-1:0] SPARE_ADDR =
    gks_pkg::PADDR_W'(4 * (gks_pkg::REG_GRID_SIDE + 1));
  localparam int ITEMS       = 500;
  localparam int IDLE_LIMIT  = 60000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic                      cmd;
    logic [gks_pkg::POS_W-1:0] row;
    logic [gks_pkg::POS_W-1:0] col;
    logic                      dir;
  } edge_word_t;

  typedef struct packed {
    logic                        linked;
    logic                        done;
    logic                        bad;
    logic [gks_pkg::COUNT_W-1:0] sets;
  } merge_res_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [gks_pkg::PADDR_W-1:0] paddr = '0;
  logic [gks_pkg::PDATA_W-1:0] pwdata = '0;
  logic [gks_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        cmd_i = 1'b0;
  logic [gks_pkg::POS_W-1:0]   row_i = '0;
  logic [gks_pkg::POS_W-1:0]   col_i = '0;
  logic                        dir_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        linked_o;
  logic                        done_res_o;
  logic                        bad_edge_o;
  logic [gks_pkg::COUNT_W-1:0] sets_left_o;

  // predictor state
  logic [gks_pkg::ADDR_W-1:0]  label_mem [gks_pkg::CELLS];
  logic [gks_pkg::COUNT_W-1:0] sets_model;
  logic [gks_pkg::SIDE_W-1:0]  side_reg;

  edge_word_t edge_words_q [$];
  merge_res_t expected_merges_q [$];
  edge_word_t word_now;

  int unsigned words_made, words_in, results_seen, mismatches, phases_run;
  int unsigned merges_seen, bad_seen, restarts_seen, single_set_hits;
  int unsigned idle_cycles;

  always #4 clk_i = ~clk_i;

  grid_kruskal_set_merge DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .dir_i       (dir_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .linked_o    (linked_o),
    .done_res_o  (done_res_o),
    .bad_edge_o  (bad_edge_o),
    .sets_left_o (sets_left_o)
  );

  function automatic int unsigned side_now();
    int unsigned s;
    s = side_reg;
    if (s < gks_pkg::MIN_SIDE) s = gks_pkg::MIN_SIDE;
    if (s > gks_pkg::MAX_SIDE) s = gks_pkg::MAX_SIDE;
    return s;
  endfunction

  function automatic void relabel_all();
    int unsigned s;
    s = side_now();
    for (int i = 0; i < gks_pkg::CELLS; i++) label_mem[i] = gks_pkg::ADDR_W'(i);
    sets_model = gks_pkg::COUNT_W'(s * s);
  endfunction

  function automatic merge_res_t merge_step(edge_word_t w);
    int unsigned s, r2, c2, a, b;
    logic [gks_pkg::ADDR_W-1:0] win, lose;
    merge_res_t res;
    s = side_now();
    res = '0;
    if (w.cmd == gks_pkg::CMD_RESTART) begin
      relabel_all();
      restarts_seen++;
    end else begin
      r2 = w.row;
      c2 = w.col;
      if (w.dir == gks_pkg::DIR_RIGHT) c2++;
      else r2++;
      if (w.row >= s || w.col >= s || r2 >= s || c2 >= s) begin
        res.bad = 1'b1;
        bad_seen++;
      end else if (sets_model > 1) begin
        a = w.row * s + w.col;
        b = r2 * s + c2;
        win = label_mem[a];
        lose = label_mem[b];
        if (win != lose) begin
          for (int i = 0; i < s * s; i++)
            if (label_mem[i] == lose) label_mem[i] = win;
          sets_model--;
          res.linked = 1'b1;
          merges_seen++;
          if (sets_model == 1) single_set_hits++;
        end
      end
    end
    res.done = (sets_model == 1);
    res.sets = sets_model;
    return res;
  endfunction

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t ns result %0d %s: got %0d, want %0d", $time, results_seen, field, got,
             want);
    mismatches++;
  endtask

  task automatic enqueue_word(edge_word_t w);
    edge_words_q = {edge_words_q, w};
    words_made++;
  endtask

  task automatic put_edge(int unsigned r, int unsigned c, logic d);
    enqueue_word('{CMD_EDGE, gks_pkg::POS_W'(r), gks_pkg::POS_W'(c), d});
  endtask

  task automatic put_restart();
    enqueue_word('{gks_pkg::CMD_RESTART, gks_pkg::POS_W'($urandom),
                   gks_pkg::POS_W'($urandom), 1'($urandom)});
  endtask

  task automatic put_noise();
    enqueue_word('{1'($urandom), gks_pkg::POS_W'($urandom_range(0, 63)),
                   gks_pkg::POS_W'($urandom_range(0, 63)), 1'($urandom)});
  endtask

  task automatic wait_idle();
    while (edge_words_q.size() != 0 || in_valid_i || expected_merges_q.size() != 0 ||
           !in_ready_o)
      @(posedge clk_i);
  endtask

  task automatic apb_write(logic [gks_pkg::PADDR_W-1:0] addr,
                           logic [gks_pkg::PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SIDE_ADDR) begin
      side_reg = data[gks_pkg::SIDE_W-1:0];
      relabel_all();
    end
  endtask

  task automatic apb_check_side();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SIDE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== gks_pkg::PDATA_W'(side_reg))
      flag_mismatch("grid_side readback", prdata, side_reg);
  endtask

  // one phase: restart, then up to cap shuffled grid edges mixed with noise
  task automatic build_phase(int unsigned s, int unsigned cap);
    edge_word_t links [$];
    edge_word_t tmp;
    int unsigned j, roll, taken;
    for (int r = 0; r < s; r++)
      for (int c = 0; c < s; c++) begin
        if (c + 1 < s)
          links = {links, edge_word_t'{CMD_EDGE, gks_pkg::POS_W'(r), gks_pkg::POS_W'(c),
                                       gks_pkg::DIR_RIGHT}};
        if (r + 1 < s)
          links = {links, edge_word_t'{CMD_EDGE, gks_pkg::POS_W'(r), gks_pkg::POS_W'(c),
                                       DIR_DOWN}};
      end
    for (int i = links.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = links[i];
      links[i] = links[j];
      links[j] = tmp;
    end
    put_restart();
    taken = 0;
    foreach (links[i]) begin
      if (taken >= cap) break;
      roll = $urandom_range(0, 99);
      if (roll < 8) put_noise();
      else if (roll < 10) put_restart();
      enqueue_word(links[i]);
      taken++;
    end
    repeat (3) put_edge($urandom_range(0, s - 1), $urandom_range(0, s - 1), 1'($urandom));
  endtask

  // sender: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_merges_q = {expected_merges_q, merge_step(word_now)};
        words_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (edge_words_q.size() != 0) begin
          word_now = edge_words_q.pop_front();
          cmd_i      <= word_now.cmd;
          row_i      <= word_now.row;
          col_i      <= word_now.col;
          dir_i      <= word_now.dir;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus long hold-offs
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 60;
  merge_res_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_merges_q.size() == 0) begin
          flag_mismatch("unexpected word", sets_left_o, 0);
        end else begin
          want = expected_merges_q.pop_front();
          if (linked_o !== want.linked) flag_mismatch("linked", linked_o, want.linked);
          if (done_res_o !== want.done) flag_mismatch("done_res", done_res_o, want.done);
          if (bad_edge_o !== want.bad) flag_mismatch("bad_edge", bad_edge_o, want.bad);
          if (sets_left_o !== want.sets) flag_mismatch("sets_left", sets_left_o, want.sets);
        end
        results_seen++;
      end
      if (hold_left == 0 && results_seen >= next_hold_at && edge_words_q.size() > 4) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 250;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(16, 96);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("grid_kruskal_set_merge: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned val, cap, pick;
    idle_cycles = 0;
    side_reg = gks_pkg::SIDE_RESET;
    relabel_all();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-size grid after reset
    put_edge(0, 0, gks_pkg::DIR_RIGHT);
    put_edge(63, 62, gks_pkg::DIR_RIGHT);
    put_edge(62, 63, DIR_DOWN);
    put_edge(0, 0, gks_pkg::DIR_RIGHT);
    put_edge(63, 63, gks_pkg::DIR_RIGHT);
    put_edge(63, 63, DIR_DOWN);
    put_edge(0, 63, gks_pkg::DIR_RIGHT);
    put_edge(63, 0, DIR_DOWN);
    put_edge(0, 1, DIR_DOWN);
    enqueue_word('{gks_pkg::CMD_RESTART, 6'h3f, 6'h3f, DIR_DOWN});
    put_edge(31, 32, DIR_DOWN);
    wait_idle();

    // side 0 clamps to the smallest grid; run it to a single set
    apb_write(SIDE_ADDR, '0);
    apb_check_side();
    put_edge(0, 0, gks_pkg::DIR_RIGHT);
    put_edge(0, 0, DIR_DOWN);
    put_edge(0, 1, DIR_DOWN);
    put_edge(1, 0, gks_pkg::DIR_RIGHT);
    put_edge(1, 1, gks_pkg::DIR_RIGHT);
    put_edge(1, 0, DIR_DOWN);
    enqueue_word('{gks_pkg::CMD_RESTART, 6'h00, 6'h00, gks_pkg::DIR_RIGHT});
    wait_idle();

    // write to an unmapped address must leave side and labels alone
    apb_write(SPARE_ADDR, 32'd5);
    put_edge(2, 0, gks_pkg::DIR_RIGHT);
    wait_idle();

    // only the low seven bits count
    apb_write(SIDE_ADDR, 32'hffff_ff81);
    apb_check_side();
    put_edge(0, 0, DIR_DOWN);
    wait_idle();

    apb_write(SIDE_ADDR, 32'h0000_007f);
    apb_check_side();
    put_edge(0, 0, gks_pkg::DIR_RIGHT);
    put_restart();
    wait_idle();

    while (words_made < ITEMS) begin
      if (phases_run == 3) begin
        val = $urandom_range(64, 127);
        cap = 8;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) val = $urandom_range(0, 6);
        else if (pick <= 8) val = $urandom_range(7, 10);
        else val = $urandom_range(11, 16);
        cap = 70;
      end
      wait_idle();
      apb_write(SIDE_ADDR, ($urandom & 32'hffff_ff80) | val);
      build_phase(side_now(), cap);
      phases_run++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d words over %0d random grid phases: %0d merges, %0d off-grid edges,",
             words_in, phases_run, merges_seen, bad_seen);
    $display("  %0d restarts, %0d runs down to a single set, %0d results checked",
             restarts_seen, single_set_hits, results_seen);
    if (mismatches == 0) begin
      $display("grid_kruskal_set_merge: match");
    end else begin
      $display("grid_kruskal_set_merge: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gks_pkg.sv
hw/rtl/gks_ram.sv
hw/rtl/gks_ctrl.sv
hw/rtl/gks_dp.sv
hw/rtl/grid_kruskal_set_merge.sv
sim/testbench.sv
